// File: rtl/segment_point_distance_sq_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment distance block
// Shared concurrent check forms, clocked on clk_i, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POINT_DISTANCE_SQ_DEFINES_SVH
`define SEGMENT_POINT_DISTANCE_SQ_DEFINES_SVH

// Same-cycle or fixed-delay implication, property written out by the caller
`define SPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the segment distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  // field widths fixed by the interface
  localparam int unsigned FIELD_W = 12;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIST_W  = 26;
  localparam int unsigned NUM_REGS = 6;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } cfg_reg_e;

  // control bits that travel with each request through the pipe
  typedef struct packed {
    logic valid;
    logic interior;
  } spd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spd_div.sv
// ----------------------------------------------------------------------------
// spd_div
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// 2W bits and its quotient by the W-bit divisor is known to fit in W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_div
  import spd_pkg::*;
#(
  parameter int unsigned W = 26
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spd_ctrl_t      ctrl_i,
  input  wire logic [2*W-1:0] num_i,
  input  wire logic [W-1:0]   den_i,
  input  wire logic [W-1:0]   alt_i,
  output spd_ctrl_t           ctrl_o,
  output logic [W-1:0]        quot_o,
  output logic [W-1:0]        alt_o
);

  spd_ctrl_t        ctrl_q [W];
  logic [W-1:0]     rem_q  [W];
  logic [W-1:0]     lo_q   [W];
  logic [W-1:0]     den_q  [W];
  logic [W-1:0]     alt_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    spd_ctrl_t    ctrl_in;
    logic [W-1:0] rem_in, lo_in, den_in, alt_in;
    logic [W:0]   trial, diff;
    logic         ge;
    logic [W-1:0] rem_d, lo_d;

    // stage input: ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign ctrl_in = ctrl_i;
      assign rem_in  = num_i[2*W-1:W];
      assign lo_in   = num_i[W-1:0];
      assign den_in  = den_i;
      assign alt_in  = alt_i;
    end else begin : g_next
      assign ctrl_in = ctrl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign den_in  = den_q[k-1];
      assign alt_in  = alt_q[k-1];
    end

    // one trial subtraction; quotient bit shifts in as dividend bit leaves
    always_comb begin
      trial = {rem_in, lo_in[W-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      lo_d  = {lo_in[W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else begin
        ctrl_q[k] <= ctrl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      lo_q[k]  <= lo_d;
      den_q[k] <= den_in;
      alt_q[k] <= alt_in;
    end
  end

  assign ctrl_o = ctrl_q[W-1];
  assign quot_o = lo_q[W-1];
  assign alt_o  = alt_q[W-1];

endmodule

`default_nettype wire

// File: rtl/segment_point_distance_sq.sv
// ----------------------------------------------------------------------------
// segment_point_distance_sq
// Squared distance from a streamed query point to a configured 3D segment.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   query    | start_i, busy_o (always 0)| point_x_i, point_y_i, point_z_i
//   result   | valid_o strobe, 1 cycle   | dist_sq_o, interior_o
//   config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One query is taken every cycle; each result passes through five front stages
// and then the bit-per-stage divider. The front stages form differences,
// per-axis products, dot sums, the two wide products and the numerator. No
// clearing pass after reset: coordinate registers reset to zero at once. The
// receiver cannot stall, so the pipe never holds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_point_distance_sq_defines.svh"

module segment_point_distance_sq
  import spd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [FIELD_W-1:0] point_x_i,
  input  wire logic [FIELD_W-1:0] point_y_i,
  input  wire logic [FIELD_W-1:0] point_z_i,
  output logic                    valid_o,
  output logic [DIST_W-1:0]       dist_sq_o,
  output logic                    interior_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [IDX_W-1:0]   cfg_index_i,
  input  wire logic [FIELD_W-1:0] cfg_data_i
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned D    = C + 1;
  localparam int unsigned P_W  = 2 * D;
  localparam int unsigned AV_W = 2 * C + 3;
  localparam int unsigned SQ_W = 2 * C + 2;
  localparam int unsigned LAT  = 5 + SQ_W;

  // configuration registers
  logic [FIELD_W-1:0] reg_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) reg_q[i] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_START_X: reg_q[0] <= cfg_data_i;
        REG_START_Y: reg_q[1] <= cfg_data_i;
        REG_START_Z: reg_q[2] <= cfg_data_i;
        REG_END_X:   reg_q[3] <= cfg_data_i;
        REG_END_Y:   reg_q[4] <= cfg_data_i;
        REG_END_Z:   reg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinates from their low C bits, sign extended by one
  logic signed [D-1:0] pt [3];
  logic signed [D-1:0] sp [3];
  logic signed [D-1:0] ep [3];
  logic [FIELD_W-1:0]  pin [3];

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = {pin[i][C-1], pin[i][C-1:0]};
      sp[i] = {reg_q[i][C-1], reg_q[i][C-1:0]};
      ep[i] = {reg_q[3+i][C-1], reg_q[3+i][C-1:0]};
    end
  end

  wire logic accept = start_i && !busy_o;

  // stage 1: difference vectors
  logic                s1_valid_q;
  logic signed [D-1:0] s1_v_q [3];
  logic signed [D-1:0] s1_w_q [3];
  logic signed [D-1:0] s1_a_q [3];

  // stage 2: per-axis products
  logic                  s2_valid_q;
  logic signed [P_W-1:0] s2_vv_q [3];
  logic signed [P_W-1:0] s2_ww_q [3];
  logic signed [P_W-1:0] s2_aa_q [3];
  logic signed [P_W-1:0] s2_av_q [3];
  logic signed [P_W-1:0] s2_aw_q [3];

  // stage 3: dot products
  logic                   s3_valid_q;
  logic signed [AV_W-1:0] s3_vv_q, s3_ww_q, s3_aa_q, s3_av_q, s3_aw_q;

  // stage 4: branch decision and wide products
  spd_ctrl_t          s4_ctrl_q;
  logic [2*SQ_W-1:0]  s4_p1_q, s4_p2_q;
  logic [SQ_W-1:0]    s4_aa_q, s4_min_q;

  // stage 5: numerator
  spd_ctrl_t          s5_ctrl_q;
  logic [2*SQ_W-1:0]  s5_num_q;
  logic [SQ_W-1:0]    s5_aa_q, s5_min_q;

  // stage 4 decision logic
  logic [SQ_W-1:0] vv3, ww3, aa3, avm3;
  logic            inside3;

  always_comb begin
    vv3     = s3_vv_q[SQ_W-1:0];
    ww3     = s3_ww_q[SQ_W-1:0];
    aa3     = s3_aa_q[SQ_W-1:0];
    avm3    = s3_av_q[SQ_W-1:0];
    inside3 = !s3_av_q[AV_W-1] && (s3_av_q != '0) && s3_aw_q[AV_W-1] && (aa3 != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_ctrl_q  <= '0;
      s5_ctrl_q  <= '0;
    end else begin
      s1_valid_q         <= accept;
      s2_valid_q         <= s1_valid_q;
      s3_valid_q         <= s2_valid_q;
      s4_ctrl_q.valid    <= s3_valid_q;
      s4_ctrl_q.interior <= s3_valid_q && inside3;
      s5_ctrl_q          <= s4_ctrl_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_v_q[i]  <= pt[i] - sp[i];
      s1_w_q[i]  <= pt[i] - ep[i];
      s1_a_q[i]  <= ep[i] - sp[i];
      s2_vv_q[i] <= P_W'(s1_v_q[i]) * P_W'(s1_v_q[i]);
      s2_ww_q[i] <= P_W'(s1_w_q[i]) * P_W'(s1_w_q[i]);
      s2_aa_q[i] <= P_W'(s1_a_q[i]) * P_W'(s1_a_q[i]);
      s2_av_q[i] <= P_W'(s1_a_q[i]) * P_W'(s1_v_q[i]);
      s2_aw_q[i] <= P_W'(s1_a_q[i]) * P_W'(s1_w_q[i]);
    end
    s3_vv_q <= AV_W'(s2_vv_q[0]) + AV_W'(s2_vv_q[1]) + AV_W'(s2_vv_q[2]);
    s3_ww_q <= AV_W'(s2_ww_q[0]) + AV_W'(s2_ww_q[1]) + AV_W'(s2_ww_q[2]);
    s3_aa_q <= AV_W'(s2_aa_q[0]) + AV_W'(s2_aa_q[1]) + AV_W'(s2_aa_q[2]);
    s3_av_q <= AV_W'(s2_av_q[0]) + AV_W'(s2_av_q[1]) + AV_W'(s2_av_q[2]);
    s3_aw_q <= AV_W'(s2_aw_q[0]) + AV_W'(s2_aw_q[1]) + AV_W'(s2_aw_q[2]);
    s4_p1_q  <= (2*SQ_W)'(vv3) * (2*SQ_W)'(aa3);
    s4_p2_q  <= (2*SQ_W)'(avm3) * (2*SQ_W)'(avm3);
    s4_aa_q  <= aa3;
    s4_min_q <= (vv3 < ww3) ? vv3 : ww3;
    // numerator is never negative for a true projection
    s5_num_q <= s4_ctrl_q.interior ? (s4_p1_q - s4_p2_q) : '0;
    s5_aa_q  <= s4_aa_q;
    s5_min_q <= s4_min_q;
  end

  // divider stages
  spd_ctrl_t       div_ctrl;
  logic [SQ_W-1:0] div_quot, div_min;

  spd_div #(
    .W (SQ_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (s5_ctrl_q),
    .num_i  (s5_num_q),
    .den_i  (s5_aa_q),
    .alt_i  (s5_min_q),
    .ctrl_o (div_ctrl),
    .quot_o (div_quot),
    .alt_o  (div_min)
  );

  // result select
  assign valid_o    = div_ctrl.valid;
  assign interior_o = div_ctrl.interior;
  assign dist_sq_o  = DIST_W'(div_ctrl.interior ? div_quot : div_min);

  // checks
  `SPD_ASSERT(a_latency, (accept |-> ##LAT valid_o), "request lost in pipe")
  `SPD_ASSERT(a_no_spurious, (!accept |-> ##LAT !valid_o), "result without request")
  `SPD_ASSERT_NEXT(a_s1_follow, accept, s1_valid_q, "stage 1 missed a request")
  `SPD_ASSERT(a_inside_den, (s4_ctrl_q.interior |-> (s4_aa_q != '0 && s4_ctrl_q.valid)),
              "interior branch with zero segment")

endmodule

`default_nettype wire

// File: tb/segment_point_distance_sq_tb.sv
// ----------------------------------------------------------------------------
// segment_point_distance_sq_tb
// Streams query points against a series of configured segments and compares
// every distance result, in order, with a predicted squared distance and
// interior flag. Idle bursts on the request side cover the pipe's phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_point_distance_sq_tb;
  import spd_pkg::*;

  localparam int unsigned CBITS     = 12;
  localparam int unsigned LAT       = 5 + 2 * CBITS + 2;
  localparam longint      MAX_CYC   = 400000;
  localparam int unsigned N_RANDOM  = 1250;

  // expected distance result
  typedef struct {
    logic [DIST_W-1:0] dsq;
    logic              interior;
  } dist_exp_t;

  // predicts results from the segment corners and checks them in order
  class dist_scoreboard;
    logic [FIELD_W-1:0] corner [NUM_REGS];
    dist_exp_t          pending [$];
    int unsigned        n_errors;
    int unsigned        n_checked;
    int unsigned        n_interior;

    function void write_reg(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
      if (idx < NUM_REGS) corner[idx] = val;
    endfunction

    function void note_request(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                               logic [FIELD_W-1:0] pz);
      longint s [3];
      longint e [3];
      longint p [3];
      longint a [3];
      longint v [3];
      longint w [3];
      longint vv, ww, aa, av, aw, num;
      dist_exp_t r;
      logic [FIELD_W-1:0] pin [3];
      pin[0] = px; pin[1] = py; pin[2] = pz;
      vv = 0; ww = 0; aa = 0; av = 0; aw = 0;
      for (int i = 0; i < 3; i++) begin
        s[i] = longint'($signed(corner[i][CBITS-1:0]));
        e[i] = longint'($signed(corner[3+i][CBITS-1:0]));
        p[i] = longint'($signed(pin[i][CBITS-1:0]));
        a[i] = e[i] - s[i];
        v[i] = p[i] - s[i];
        w[i] = p[i] - e[i];
        vv += v[i] * v[i];
        ww += w[i] * w[i];
        aa += a[i] * a[i];
        av += a[i] * v[i];
        aw += a[i] * w[i];
      end
      if (av > 0 && aw < 0 && aa > 0) begin
        num = vv * aa - av * av;
        if (num < 0) num = 0;
        r.dsq = DIST_W'(num / aa);
        r.interior = 1'b1;
      end else begin
        r.dsq = DIST_W'(vv < ww ? vv : ww);
        r.interior = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [DIST_W-1:0] dsq, logic interior);
      dist_exp_t x;
      if (pending.size() == 0) begin
        $error("unexpected result dist_sq=%0d interior=%0d", dsq, interior);
        n_errors++;
        return;
      end
      x = pending.pop_front();
      n_checked++;
      if (x.interior) n_interior++;
      if (dsq !== x.dsq) begin
        $error("dist_sq mismatch: expected %0d, actual %0d", x.dsq, dsq);
        n_errors++;
      end
      if (interior !== x.interior) begin
        $error("interior mismatch: expected %0d, actual %0d", x.interior, interior);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [FIELD_W-1:0] point_x_i = '0;
  logic [FIELD_W-1:0] point_y_i = '0;
  logic [FIELD_W-1:0] point_z_i = '0;
  logic               valid_o;
  logic [DIST_W-1:0]  dist_sq_o;
  logic               interior_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [IDX_W-1:0]   cfg_index_i = '0;
  logic [FIELD_W-1:0] cfg_data_i = '0;

  dist_scoreboard sb;
  longint         cycle_cnt = 0;
  bit             allow_idle = 1'b1;
  int unsigned    n_requests = 0;

  always #5 clk_i = ~clk_i;

  segment_point_distance_sq #(.COORD_BITS(CBITS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .valid_o    (valid_o),
    .dist_sq_o  (dist_sq_o),
    .interior_o (interior_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // result monitor and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && valid_o) sb.check_result(dist_sq_o, interior_o);
    if (cycle_cnt > MAX_CYC) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  // one register write on the config channel, then valid is dropped before the next
  task automatic write_reg(cfg_reg_e idx, logic [FIELD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // out-of-range index: block must ignore it
  task automatic write_bad_index(logic [FIELD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= IDX_W'(NUM_REGS + $urandom_range(0, 1));
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_segment(logic [FIELD_W-1:0] sx, logic [FIELD_W-1:0] sy,
                             logic [FIELD_W-1:0] sz, logic [FIELD_W-1:0] ex,
                             logic [FIELD_W-1:0] ey, logic [FIELD_W-1:0] ez);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_END_Z, ez);
  endtask

  // one query request, with an optional idle burst before it
  task automatic send_point(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
                            logic [FIELD_W-1:0] pz);
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(px, py, pz);
    n_requests++;
    @(negedge clk_i);
  endtask

  // wait for the pipe to drain before touching the registers
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [FIELD_W-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 12'h800;
      1: return 12'h7FF;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // point near the segment so both branches show up often
  task automatic send_near_point();
    logic [FIELD_W-1:0] c [3];
    int t;
    t = $urandom_range(0, 16);
    for (int i = 0; i < 3; i++) begin
      int sv, ev, r;
      sv = $signed(sb.corner[i]);
      ev = $signed(sb.corner[3+i]);
      r = sv + ((ev - sv) * t) / 16 + $signed($urandom_range(0, 64)) - 32;
      if (r > 2047) r = 2047;
      if (r < -2048) r = -2048;
      c[i] = FIELD_W'(r);
    end
    send_point(c[0], c[1], c[2]);
  endtask

  initial begin
    int unsigned n_seg;
    sb = new();
    for (int i = 0; i < NUM_REGS; i++) sb.corner[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset corners give a degenerate segment at the origin
    send_point(12'h000, 12'h000, 12'h000);
    send_point(12'h800, 12'h800, 12'h800);
    send_point(12'h7FF, 12'h7FF, 12'h7FF);
    drain();

    // longest diagonal, extremes of every coordinate
    set_segment(12'h800, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 12'h7FF);
    write_bad_index(12'h123);
    send_point(12'h000, 12'h000, 12'h000);
    send_point(12'h7FF, 12'h800, 12'h800);
    send_point(12'h800, 12'h7FF, 12'h7FF);
    send_point(12'h800, 12'h800, 12'h800);
    send_point(12'h7FF, 12'h7FF, 12'h7FF);
    send_point(12'hFFF, 12'h001, 12'h555);
    drain();

    // axis segment: points on the end normal planes take the endpoint branch
    set_segment(12'd0, 12'd0, 12'd0, 12'd100, 12'd0, 12'd0);
    send_point(12'd0, 12'd50, 12'd0);
    send_point(12'd100, 12'd50, 12'd7);
    send_point(12'd1, 12'd50, 12'd0);
    send_point(12'd99, 12'hFCE, 12'd3);
    send_point(12'd50, 12'd0, 12'd0);
    send_point(12'hFFF, 12'd0, 12'd0);
    send_point(12'd101, 12'd0, 12'd0);
    send_point(12'hAAA, 12'h555, 12'hAAA);
    drain();

    // degenerate nonzero segment
    set_segment(12'd300, 12'hF00, 12'd7, 12'd300, 12'hF00, 12'd7);
    send_point(12'd301, 12'hF00, 12'd7);
    send_point(12'h7FF, 12'h7FF, 12'h800);
    drain();

    // random segments with mostly near points and some anywhere
    n_seg = 0;
    while (n_requests < N_RANDOM + 25) begin
      if (n_seg % 5 == 4) begin
        logic [FIELD_W-1:0] sx, sy, sz;
        sx = rnd_coord(); sy = rnd_coord(); sz = rnd_coord();
        set_segment(sx, sy, sz, sx + FIELD_W'($urandom_range(0, 3)), sy, sz);
      end else begin
        set_segment(rnd_coord(), rnd_coord(), rnd_coord(),
                    rnd_coord(), rnd_coord(), rnd_coord());
      end
      if ($urandom_range(0, 3) == 0) write_bad_index(FIELD_W'($urandom));
      n_seg++;
      // last stretch runs without idle bursts
      allow_idle = (n_requests < N_RANDOM - 200);
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 3) == 0) send_point(rnd_coord(), rnd_coord(), rnd_coord());
        else send_near_point();
      end
      drain();
    end

    repeat (LAT + 10) @(negedge clk_i);
    $display("covered %0d queries over %0d random segments plus directed cases",
             n_requests, n_seg);
    $display("checked %0d results, %0d on the interior branch",
             sb.n_checked, sb.n_interior);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
